[design/twl_pkg.sv]
package twl_pkg;

    // list geometry
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int TASK_W     = 8;
    localparam int WAIT_W     = 16;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_POP  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // result codes carried on m_tuser
    typedef enum logic [2:0] {
        EV_ADDED    = 3'd0,
        EV_FULL     = 3'd1,
        EV_POPPED   = 3'd2,
        EV_EMPTY    = 3'd3,
        EV_TIMEOUT  = 3'd4,
        EV_TICKDONE = 3'd5
    } ev_t;

    // operation applied to every cell of the row together
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_APPEND = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_TICK = 1'b1
    } state_t;

    // one list entry as held by a cell
    typedef struct packed {
        logic              valid;
        logic              untimed;
        logic [WAIT_W-1:0] wait_cnt;
        logic [TASK_W-1:0] task_id;
    } twl_entry_t;

    // controller to cell row
    typedef struct packed {
        cell_op_t   op;
        logic       keep;
        twl_entry_t fb;
    } cell_ctrl_t;

    // cell row to controller
    typedef struct packed {
        twl_entry_t head;
        logic       full;
        logic       empty;
    } row_stat_t;

endpackage

[design/twl_cell.sv]
module twl_cell
    import twl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  twl_entry_t left_in,
    input  twl_entry_t right_in,
    output twl_entry_t entry_out
);

    twl_entry_t entry_reg;
    twl_entry_t entry_next;

    // next entry for the row-wide operation
    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_PUSH: begin
                entry_next = left_in;
            end
            OP_APPEND: begin
                // first empty slot takes the new entry
                if (!entry_reg.valid && left_in.valid) begin
                    entry_next = ctrl.fb;
                end
            end
            OP_ROTATE: begin
                if (right_in.valid) begin
                    entry_next = right_in;
                end else if (entry_reg.valid) begin
                    // tail cell: takes the recycled head or empties
                    if (ctrl.keep) begin
                        entry_next = ctrl.fb;
                    end else begin
                        entry_next.valid = 1'b0;
                    end
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // valid bit is control state and is reset, payload is not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.untimed  <= entry_next.untimed;
        entry_reg.wait_cnt <= entry_next.wait_cnt;
        entry_reg.task_id  <= entry_next.task_id;
    end

    assign entry_out = entry_reg;

endmodule

[design/twl_ctrl.sv]
module twl_ctrl
    import twl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,
    input  logic [TASK_W-1:0]   in_task,
    input  logic [WAIT_W-1:0]   in_wait,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          m_tuser,
    output logic [TASK_W-1:0]   out_task,
    output logic                m_tlast,
    input  row_stat_t           stat,
    output cell_ctrl_t          ctrl
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              in_run_reg, in_run_next;
    logic              m_valid_reg, m_valid_next;
    ev_t               ev_reg, ev_next;
    logic [TASK_W-1:0] task_reg, task_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              accept;
    kind_t             kind;
    logic              run_now;
    logic [WAIT_W-1:0] dec_wait;
    logic              drop;
    logic              step_go;
    logic              done_go;
    logic              load;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);

    // head of the list during a tick walk
    assign run_now  = in_run_reg && !stat.head.untimed;
    assign dec_wait = stat.head.wait_cnt - WAIT_W'(1);
    assign drop     = run_now && (dec_wait == '0);
    assign step_go  = (state_reg == ST_TICK) && (rem_reg != '0) && (!drop || out_free);
    assign done_go  = (state_reg == ST_TICK) && (rem_reg == '0) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && kind == KIND_TICK) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (done_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: row control, counters and result register
    always_comb begin
        ctrl        = '{op: OP_HOLD, keep: 1'b0, fb: '0};
        count_next  = count_reg;
        rem_next    = rem_reg;
        in_run_next = in_run_reg;
        load        = 1'b0;
        ev_next     = ev_reg;
        task_next   = task_reg;
        last_next   = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // new entry from the request, also fed to cell 0
                ctrl.fb.valid    = 1'b1;
                ctrl.fb.untimed  = (in_wait == '0);
                ctrl.fb.wait_cnt = in_wait;
                ctrl.fb.task_id  = in_task;
                if (accept) begin
                    unique case (kind)
                        KIND_ADD: begin
                            load      = 1'b1;
                            task_next = '0;
                            last_next = 1'b1;
                            if (stat.full) begin
                                ev_next = EV_FULL;
                            end else begin
                                ev_next    = EV_ADDED;
                                count_next = count_reg + CNT_W'(1);
                                ctrl.op    = (in_wait == '0) ? OP_APPEND : OP_PUSH;
                            end
                        end
                        KIND_POP: begin
                            load      = 1'b1;
                            last_next = 1'b1;
                            if (stat.empty) begin
                                ev_next   = EV_EMPTY;
                                task_next = '0;
                            end else begin
                                ev_next    = EV_POPPED;
                                task_next  = stat.head.task_id;
                                count_next = count_reg - CNT_W'(1);
                                ctrl.op    = OP_ROTATE;
                                ctrl.keep  = 1'b0;
                            end
                        end
                        KIND_TICK: begin
                            rem_next    = count_reg;
                            in_run_next = 1'b1;
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // recycled head goes to the tail, decremented while in the run
                ctrl.fb          = stat.head;
                ctrl.fb.wait_cnt = run_now ? dec_wait : stat.head.wait_cnt;
                if (step_go) begin
                    ctrl.op     = OP_ROTATE;
                    ctrl.keep   = !drop;
                    rem_next    = rem_reg - CNT_W'(1);
                    in_run_next = run_now;
                    if (drop) begin
                        count_next = count_reg - CNT_W'(1);
                        load       = 1'b1;
                        ev_next    = EV_TIMEOUT;
                        task_next  = stat.head.task_id;
                        last_next  = 1'b0;
                    end
                end else if (done_go) begin
                    load      = 1'b1;
                    ev_next   = EV_TICKDONE;
                    task_next = '0;
                    last_next = 1'b1;
                end
            end
            default: begin
                ctrl.op = OP_HOLD;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            in_run_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            in_run_reg  <= in_run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        ev_reg   <= ev_next;
        task_reg <= task_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ev_reg;
    assign out_task = task_reg;
    assign m_tlast  = last_reg;

    // count must agree with the valid bits of the row
    a_full_match: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full == (count_reg == CNT_W'(LIST_DEPTH)))
        else $error("count and full flag disagree");

    a_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.empty == (count_reg == '0))
        else $error("count and empty flag disagree");

    // entries still to visit never exceed entries held
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) |-> (rem_reg <= count_reg))
        else $error("tick walk overruns the list");

    // a timeout result is never the closing one
    a_timeout_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ev_reg == EV_TIMEOUT) |-> !last_reg)
        else $error("timeout result flagged last");

endmodule

[design/timed_wait_list.sv]
// Timed wait list: up to 16 blocked task ids, each with a remaining wait.
// Requests arrive on the s_ channel: s_tuser is the kind (add, pop, tick;
// the fourth code is taken and ignored), s_tdata carries task id and wait.
// Results leave on the m_ channel: m_tuser is the result code, m_tdata the
// task id, m_tlast marks the final result of a request.
// Add and pop give one result, held in the output register from the cycle
// after the request is taken; the next request may be taken in that cycle.
// A tick walks the row of cells one entry per cycle by rotating the list
// through cell 0, while no held result blocks a release, then closes with
// a tick-done result once every entry held has been visited; no request is
// taken meanwhile.
// The single output register lets a request be taken in the cycle the last
// result is taken; while m_tready is low a pending result holds, s_tready
// drops and a tick walk pauses at the next entry that is to be released.
// Reset (aresetn low, synchronous) empties the list and the output register.
module timed_wait_list
    import twl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [23:0] s_tdata,   // [7:0] task_id, [23:8] wait_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic [7:0]  m_tdata,   // [7:0] out_task
    output logic        m_tlast
);

    cell_ctrl_t ctrl;
    row_stat_t  stat;
    twl_entry_t entry_q [LIST_DEPTH];

    twl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .in_task  (s_tdata[TASK_W-1:0]),
        .in_wait  (s_tdata[TASK_W+WAIT_W-1:TASK_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .out_task (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // row of cells, cell 0 is the list head
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        twl_entry_t left_in;
        twl_entry_t right_in;

        if (i == 0) begin : g_first
            assign left_in = ctrl.fb;
        end else begin : g_mid_l
            assign left_in = entry_q[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = entry_q[i+1];
        end

        twl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .left_in   (left_in),
            .right_in  (right_in),
            .entry_out (entry_q[i])
        );
    end

    // status seen by the controller
    assign stat.head  = entry_q[0];
    assign stat.full  = entry_q[LIST_DEPTH-1].valid;
    assign stat.empty = !entry_q[0].valid;

endmodule

[bench/timed_wait_list_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the timed wait list, keeps its own copy of the
// list, and compares every result against the oldest one still due.
module timed_wait_list_checker
    import twl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [23:0] s_tdata,   // [7:0] task_id, [23:8] wait_time
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [2:0]  m_tuser,   // [2:0] event_res
    input  logic [7:0]  m_tdata,   // [7:0] out_task
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    typedef struct {
        logic [TASK_W-1:0] task_id;
        logic [WAIT_W-1:0] wait_left;
        logic              untimed;
    } list_entry_t;

    typedef struct {
        ev_t               ev;
        logic [TASK_W-1:0] task_id;
        logic              last;
    } notice_t;

    list_entry_t wait_list[$];
    notice_t     due_results[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic void note_result(ev_t ev, logic [TASK_W-1:0] id, logic last);
        notice_t n;
        n.ev      = ev;
        n.task_id = id;
        n.last    = last;
        due_results.push_back(n);
    endfunction

    // walk the leading timed run, release entries that run out
    function automatic void timer_tick();
        list_entry_t kept[$];
        list_entry_t e;
        bit          in_run;
        in_run = 1'b1;
        foreach (wait_list[r]) begin
            e = wait_list[r];
            if (e.untimed)
                in_run = 1'b0;
            if (in_run) begin
                e.wait_left = e.wait_left - 1'b1;
                if (e.wait_left == '0) begin
                    note_result(EV_TIMEOUT, e.task_id, 1'b0);
                    continue;
                end
            end
            kept.push_back(e);
        end
        wait_list = kept;
        note_result(EV_TICKDONE, '0, 1'b1);
    endfunction

    // update the list for one request and queue the results it causes
    function automatic void apply_request(kind_t k, logic [TASK_W-1:0] id,
                                          logic [WAIT_W-1:0] w);
        list_entry_t e;
        case (k)
            KIND_ADD: begin
                if (wait_list.size() >= LIST_DEPTH) begin
                    note_result(EV_FULL, '0, 1'b1);
                end else begin
                    e.task_id   = id;
                    e.wait_left = w;
                    e.untimed   = (w == '0);
                    if (w == '0 || wait_list.size() == 0)
                        wait_list.push_back(e);
                    else
                        wait_list.push_front(e);
                    note_result(EV_ADDED, '0, 1'b1);
                end
            end
            KIND_POP: begin
                if (wait_list.size() == 0) begin
                    note_result(EV_EMPTY, '0, 1'b1);
                end else begin
                    e = wait_list.pop_front();
                    note_result(EV_POPPED, e.task_id, 1'b1);
                end
            end
            KIND_TICK: timer_tick();
            default: ;
        endcase
    endfunction

    function automatic void check_result();
        notice_t n;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: ev=%0d task=%0d last=%0b",
                         m_tuser, m_tdata, m_tlast);
            return;
        end
        n = due_results.pop_front();
        if (m_tuser !== n.ev || m_tdata !== n.task_id || m_tlast !== n.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected ev=%0d task=%0d last=%0b, got ev=%0d task=%0d last=%0b",
                         n.ev, n.task_id, n.last, m_tuser, m_tdata, m_tlast);
        end
    endfunction

    // a result never leaves in the cycle its request is taken, so compare before predicting
    always @(posedge aclk) begin
        if (!aresetn) begin
            wait_list.delete();
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                apply_request(kind_t'(s_tuser), s_tdata[7:0], s_tdata[23:8]);
        end
        pending = due_results.size();
    end

endmodule

[bench/timed_wait_list_test.sv]
`timescale 1ns / 1ps

module timed_wait_list_test;
    import twl_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int mismatches;
    int pending;
    bit calm = 1'b0;   // no idling on either side while set

    always #1 aclk = ~aclk;

    timed_wait_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    timed_wait_list_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver back-pressure
    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(0, 99) >= 34);

    // present one request, with random gaps ahead of it, and wait for it to go
    task automatic send_request(kind_t k, logic [7:0] id, logic [15:0] w);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {w, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // withdraw the last request, then wait for every result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // hard stop
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          issued;
        int          pick;
        logic [15:0] w;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list cases, the ignored kind, and the field extremes
        send_request(KIND_POP,  8'd0,   16'd0);
        send_request(KIND_TICK, 8'd0,   16'd0);
        send_request(KIND_NONE, 8'hFF,  16'hFFFF);
        send_request(KIND_ADD,  8'h00,  16'd0);
        send_request(KIND_ADD,  8'hFF,  16'd1);
        send_request(KIND_ADD,  8'hAA,  16'hFFFF);
        // releases 0xFF, stops at the untimed entry
        send_request(KIND_TICK, 8'd0,   16'd0);
        send_request(KIND_POP,  8'd0,   16'd0);
        // fill up to the limit, timed and untimed mixed
        for (int i = 0; i < 15; i++)
            send_request(KIND_ADD, 8'h10 + i[7:0], (i % 3 == 0) ? 16'd0 : i[15:0]);
        // rejected add into a full list
        send_request(KIND_ADD,  8'h55,  16'd7);
        send_request(KIND_TICK, 8'd0,   16'd0);

        // sender holds off until everything has come back
        drain_results();

        // random mix, weighted to keep the list busy with short waits
        issued = 0;
        while (issued < 85) begin
            calm = (issued >= 30 && issued < 55);
            if (issued == 60)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_request(KIND_NONE, 8'($urandom), 16'($urandom));
                continue;
            end
            if (pick < 45) begin
                case ($urandom_range(0, 9)) inside
                    [0:2]:   w = 16'd0;
                    8:       w = 16'($urandom_range(5, 20));
                    9:       w = 16'($urandom);
                    default: w = 16'($urandom_range(1, 4));
                endcase
                send_request(KIND_ADD, 8'($urandom), w);
            end else if (pick < 63) begin
                send_request(KIND_POP, 8'($urandom), 16'($urandom));
            end else begin
                send_request(KIND_TICK, 8'($urandom), 16'($urandom));
            end
            issued++;
        end
        calm = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_results();
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
